// ----- rtl/multichannel_dimmer_sequencer_defines.svh -----
// assertion macros for the dimmer sequencer
// no dependencies; taken in by `include where assertions are written
`ifndef MULTICHANNEL_DIMMER_SEQUENCER_DEFINES_SVH
`define MULTICHANNEL_DIMMER_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off during reset
`define MDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mds_pkg.sv -----
// shared types, widths and opcode constants of the dimmer sequencer
// no dependencies
package mds_pkg;

	// field widths of the request and report words and of the channel state
	localparam int unsigned CMD_W   = 1;
	localparam int unsigned CHAN_W  = 5;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned TICKS_W = 8;
	localparam int unsigned POS_W   = 5;

	// request kinds
	localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

	// program opcodes
	localparam logic [BYTE_W-1:0] OP_END       = 8'd0;
	localparam logic [BYTE_W-1:0] OP_RAMP_MAX  = 8'd200;
	localparam logic [BYTE_W-1:0] OP_JUMP_BASE = 8'd201;
	localparam logic [BYTE_W-1:0] OP_SET       = 8'd221;
	localparam logic [BYTE_W-1:0] OP_DELAY     = 8'd222;

	typedef enum logic [2:0] {
		OPK_END,
		OPK_RAMP,
		OPK_JUMP,
		OPK_SET,
		OPK_DELAY
	} op_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_ST,
		S_OP,
		S_VAL,
		S_DIV,
		S_WB
	} state_t;

	// per channel state as kept in the state memory
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] step;
		logic [TICKS_W-1:0] ticks;
		logic [POS_W-1:0]   pos;
	} chan_state_t;

	// divider request and response
	typedef struct packed {
		logic               start;
		logic [LEVEL_W-1:0] dividend;
		logic [BYTE_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] quotient;
	} div_rsp_t;

	// decode a program opcode
	function automatic op_kind_t op_kind(input logic [BYTE_W-1:0] op);
		op_kind_t k;
		if (op == OP_END)
			k = OPK_END;
		else if (op <= OP_RAMP_MAX)
			k = OPK_RAMP;
		else if (op < OP_SET)
			k = OPK_JUMP;
		else if (op == OP_SET)
			k = OPK_SET;
		else if (op == OP_DELAY)
			k = OPK_DELAY;
		else
			k = OPK_END;
		return k;
	endfunction

endpackage

// ----- rtl/mds_req_if.sv -----
// request channel: tick or program byte write
// depends on mds_pkg
interface mds_req_if;
	logic                        valid;
	logic                        ready;
	logic [mds_pkg::CMD_W-1:0]   command;
	logic [mds_pkg::CHAN_W-1:0]  channel;
	logic [mds_pkg::ADDR_W-1:0]  address;
	logic [mds_pkg::BYTE_W-1:0]  program_byte;

	modport source(output valid, command, channel, address, program_byte, input ready);
	modport sink(input valid, command, channel, address, program_byte, output ready);
endinterface

// ----- rtl/mds_rsp_if.sv -----
// report channel: one brightness word per channel and tick
// depends on mds_pkg
interface mds_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mds_pkg::CHAN_W-1:0]  channel_index;
	logic [mds_pkg::BYTE_W-1:0]  brightness;
	logic                        last;

	modport source(output valid, channel_index, brightness, last, input ready);
	modport sink(input valid, channel_index, brightness, last, output ready);
endinterface

// ----- rtl/mds_div.sv -----
// restoring divider, one quotient bit per cycle, 16-bit dividend by 8-bit divisor
// depends on mds_pkg
module mds_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mds_pkg::div_req_t req,
	output mds_pkg::div_rsp_t rsp
);

	localparam int unsigned QW = mds_pkg::LEVEL_W;
	localparam int unsigned DW = mds_pkg::BYTE_W;
	localparam int unsigned CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;

	logic [DW:0]   shifted;
	logic          fits;
	logic [DW:0]   diff;

	// one trial subtraction per cycle
	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		fits    = shifted >= {1'b0, div_q};
		diff    = shifted - {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/multichannel_dimmer_sequencer.sv -----
// Dimmer sequencer: CHANNELS light channels each run a byte program of PROGRAM_LENGTH
// bytes. A write word stores one program byte. A tick word walks all channels in
// order, one at a time, and sends one brightness word per channel, the last one
// marked. Per channel a tick reads the state (RD, ST) and writes it back (WB); an end or
// jump command adds the opcode step (OP), set and delay commands add OP and VAL, and
// a ramp adds OP, VAL and DIV, waiting on the serial divider. A stall on the report
// side holds the walk in WB. After reset the block clears its program and state
// memories and takes no request until that is done.
// depends on mds_pkg, mds_req_if, mds_rsp_if, mds_div and multichannel_dimmer_sequencer_defines.svh
`include "multichannel_dimmer_sequencer_defines.svh"

module multichannel_dimmer_sequencer #(
	parameter int unsigned CHANNELS       = 22,
	parameter int unsigned PROGRAM_LENGTH = 20
) (
	input logic        clk,
	input logic        arst_n,
	mds_req_if.sink    req,
	mds_rsp_if.source  rsp
);

	localparam int unsigned TOTAL = CHANNELS * PROGRAM_LENGTH;
	localparam int unsigned PAW   = $clog2(TOTAL);
	localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned LW    = mds_pkg::LEVEL_W;
	localparam int unsigned BW    = mds_pkg::BYTE_W;
	localparam int unsigned PW    = mds_pkg::POS_W;
	localparam int unsigned TW    = mds_pkg::TICKS_W;
	localparam logic [PW-1:0] PEND = PW'(PROGRAM_LENGTH);

	// memories
	logic [BW-1:0]        pg_mem [TOTAL];
	mds_pkg::chan_state_t st_mem [CHANNELS];

	logic [BW-1:0]        pg_rd_q;
	mds_pkg::chan_state_t st_rd_q;

	// control
	mds_pkg::state_t state_q, state_d;
	logic [CHW-1:0]  ch_q;
	logic            clearing_q;
	logic [PAW-1:0]  clr_q;
	logic            rsp_valid_q;

	// working registers of the channel in flight
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] step_q;
	logic [TW-1:0] ticks_q;
	logic [PW-1:0] pos_q;
	logic [BW-1:0] op_q;
	logic          opnd_ok_q;
	logic          neg_q;

	// report register
	logic [mds_pkg::CHAN_W-1:0] rsp_ch_q;
	logic [BW-1:0]              rsp_br_q;
	logic                       rsp_last_q;

	logic               st_rd_en;
	logic               pg_rd_en;
	logic [PW-1:0]      pg_rd_pos;
	logic [PAW-1:0]     pg_rd_addr;
	logic               wb_fire;
	logic               last_ch;
	logic               req_fire;
	logic               wr_ok;
	logic [PAW-1:0]     wr_addr;
	mds_pkg::op_kind_t  kind_rd;
	mds_pkg::op_kind_t  kind_op;
	logic [BW-1:0]      opnd;
	logic [LW:0]        num;
	logic [LW-1:0]      quo_s;
	logic [LW-1:0]      step_new;
	mds_pkg::div_req_t  div_req;
	mds_pkg::div_rsp_t  div_rsp;

	assign req.ready = (state_q == mds_pkg::S_IDLE) && !clearing_q;
	assign req_fire  = req.valid && req.ready;
	assign last_ch   = ch_q == CHW'(CHANNELS - 1);

	// program byte write decode
	assign wr_ok   = ({1'b0, req.channel} < 6'(CHANNELS)) &&
		({1'b0, req.address} < 6'(PROGRAM_LENGTH));
	assign wr_addr = PAW'(req.channel) * PAW'(PROGRAM_LENGTH) + PAW'(req.address);

	assign pg_rd_addr = PAW'(ch_q) * PAW'(PROGRAM_LENGTH) + PAW'(pg_rd_pos);
	assign kind_rd    = mds_pkg::op_kind(pg_rd_q);
	assign kind_op    = mds_pkg::op_kind(op_q);

	// ramp numerator and final step
	always_comb begin
		opnd     = opnd_ok_q ? pg_rd_q : '0;
		num      = {1'b0, opnd, 8'b0} - {1'b0, lvl_q};
		quo_s    = neg_q ? LW'(-div_rsp.quotient) : div_rsp.quotient;
		step_new = (quo_s != '0 && !quo_s[LW-1]) ? quo_s + 1'b1 : quo_s;
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = num[LW] ? LW'(-num) : num[LW-1:0];
		div_req.divisor  = op_q;
		if (state_q == mds_pkg::S_VAL && kind_op == mds_pkg::OPK_RAMP)
			div_req.start = 1'b1;
	end

	mds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer next state and memory strobes
	always_comb begin
		state_d   = state_q;
		st_rd_en  = 1'b0;
		pg_rd_en  = 1'b0;
		pg_rd_pos = pos_q;
		wb_fire   = 1'b0;
		unique case (state_q)
			mds_pkg::S_IDLE: begin
				if (req_fire && req.command == mds_pkg::CMD_TICK)
					state_d = mds_pkg::S_RD;
			end
			mds_pkg::S_RD: begin
				st_rd_en = 1'b1;
				state_d  = mds_pkg::S_ST;
			end
			mds_pkg::S_ST: begin
				if (st_rd_q.ticks != '0 || st_rd_q.pos >= PEND) begin
					state_d = mds_pkg::S_WB;
				end else begin
					pg_rd_en  = 1'b1;
					pg_rd_pos = st_rd_q.pos;
					state_d   = mds_pkg::S_OP;
				end
			end
			mds_pkg::S_OP: begin
				if (kind_rd == mds_pkg::OPK_END || kind_rd == mds_pkg::OPK_JUMP) begin
					state_d = mds_pkg::S_WB;
				end else begin
					pg_rd_en = pos_q < PEND;
					state_d  = mds_pkg::S_VAL;
				end
			end
			mds_pkg::S_VAL: begin
				if (kind_op == mds_pkg::OPK_RAMP)
					state_d = mds_pkg::S_DIV;
				else
					state_d = mds_pkg::S_WB;
			end
			mds_pkg::S_DIV: begin
				if (div_rsp.done)
					state_d = mds_pkg::S_WB;
			end
			mds_pkg::S_WB: begin
				if (!rsp_valid_q || rsp.ready) begin
					wb_fire = 1'b1;
					state_d = last_ch ? mds_pkg::S_IDLE : mds_pkg::S_RD;
				end
			end
			default: state_d = mds_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mds_pkg::S_IDLE;
			ch_q        <= '0;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == PAW'(TOTAL - 1))
					clearing_q <= 1'b0;
			end
			if (req_fire)
				ch_q <= '0;
			else if (wb_fire && !last_ch)
				ch_q <= ch_q + 1'b1;
			if (wb_fire)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// program memory: clearing pass or byte write, one read port
	always_ff @(posedge clk) begin
		if (clearing_q)
			pg_mem[clr_q] <= '0;
		else if (req_fire && req.command == mds_pkg::CMD_WRITE && wr_ok)
			pg_mem[wr_addr] <= req.program_byte;
		if (pg_rd_en)
			pg_rd_q <= pg_mem[pg_rd_addr];
	end

	// channel state memory: clearing pass or write-back, one read port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_q < PAW'(CHANNELS))
				st_mem[CHW'(clr_q)] <= '0;
		end else if (wb_fire) begin
			st_mem[ch_q] <= '{level: lvl_q, step: step_q, ticks: ticks_q, pos: pos_q};
		end
		if (st_rd_en)
			st_rd_q <= st_mem[ch_q];
	end

	// working registers of the channel in flight
	always_ff @(posedge clk) begin
		unique case (state_q)
			mds_pkg::S_ST: begin
				step_q <= st_rd_q.step;
				if (st_rd_q.ticks != '0) begin
					lvl_q   <= st_rd_q.level + st_rd_q.step;
					ticks_q <= st_rd_q.ticks - 1'b1;
					pos_q   <= st_rd_q.pos;
				end else begin
					lvl_q   <= st_rd_q.level;
					ticks_q <= st_rd_q.ticks;
					pos_q   <= (st_rd_q.pos < PEND) ? st_rd_q.pos + 1'b1 : st_rd_q.pos;
				end
			end
			mds_pkg::S_OP: begin
				op_q      <= pg_rd_q;
				opnd_ok_q <= pos_q < PEND;
				unique case (kind_rd)
					mds_pkg::OPK_END:  pos_q <= PEND;
					mds_pkg::OPK_JUMP: pos_q <= PW'(pg_rd_q - mds_pkg::OP_JUMP_BASE);
					default:           pos_q <= pos_q + 1'b1;
				endcase
			end
			mds_pkg::S_VAL: begin
				neg_q <= num[LW];
				unique case (kind_op)
					mds_pkg::OPK_SET: lvl_q <= {opnd, 8'b0};
					mds_pkg::OPK_DELAY: begin
						step_q  <= '0;
						ticks_q <= opnd;
					end
					default: ;
				endcase
			end
			mds_pkg::S_DIV: begin
				if (div_rsp.done) begin
					step_q  <= step_new;
					lvl_q   <= lvl_q + step_new;
					ticks_q <= op_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// report register
	always_ff @(posedge clk) begin
		if (wb_fire) begin
			rsp_ch_q   <= mds_pkg::CHAN_W'(ch_q);
			rsp_br_q   <= lvl_q[LW-1:LW-BW];
			rsp_last_q <= last_ch;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.channel_index = rsp_ch_q;
	assign rsp.brightness    = rsp_br_q;
	assign rsp.last          = rsp_last_q;

	// checks
	`MDS_ASSERT_IMPL(a_no_req_clear, clk, arst_n, clearing_q, !req.ready, "request taken during clearing pass")
	`MDS_ASSERT_NEXT(a_tick_starts, clk, arst_n, req_fire && req.command == mds_pkg::CMD_TICK, state_q == mds_pkg::S_RD, "tick did not start channel walk")
	`MDS_ASSERT_NEXT(a_div_wait, clk, arst_n, div_req.start, state_q == mds_pkg::S_DIV, "divider started outside ramp")
	`MDS_ASSERT_IMPL(a_last_mark, clk, arst_n, rsp.valid && rsp.last, rsp.channel_index == mds_pkg::CHAN_W'(CHANNELS - 1), "last mark on wrong channel")
	`MDS_ASSERT_IMPL(a_wb_no_clear, clk, arst_n, wb_fire, !clearing_q, "write-back during clearing pass")

endmodule

// ----- test/testbench.sv -----
// testbench for the multichannel dimmer sequencer: program byte writes and ticks,
// with every brightness word checked against a predictor kept in step with the block
// depends on mds_pkg, mds_req_if, mds_rsp_if and multichannel_dimmer_sequencer
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCHAN        = 22;
	localparam int PLEN         = 20;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int TAIL_CYCLES  = 600;
	localparam int HOLD_CYCLES  = 800;

	typedef struct packed {
		logic [mds_pkg::CMD_W-1:0]  command;
		logic [mds_pkg::CHAN_W-1:0] channel;
		logic [mds_pkg::ADDR_W-1:0] address;
		logic [mds_pkg::BYTE_W-1:0] program_byte;
	} request_t;

	typedef struct packed {
		logic [mds_pkg::CHAN_W-1:0] channel_index;
		logic [mds_pkg::BYTE_W-1:0] brightness;
		logic                       last;
	} report_t;

	logic clk;
	logic arst_n;

	mds_req_if req_bus();
	mds_rsp_if rsp_bus();

	multichannel_dimmer_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// words waiting to be offered and brightness words still owed by the block
	request_t pending_words[$];
	report_t  brightness_due[$];

	// predicted per channel state and program memory
	logic [mds_pkg::LEVEL_W-1:0] lamp_level   [NCHAN];
	logic [mds_pkg::LEVEL_W-1:0] lamp_step    [NCHAN];
	logic [mds_pkg::TICKS_W-1:0] lamp_wait    [NCHAN];
	logic [mds_pkg::POS_W-1:0]   lamp_pos     [NCHAN];
	logic [mds_pkg::BYTE_W-1:0]  lamp_program [NCHAN][PLEN];

	int  send_idle;
	int  recv_idle;
	int  phase_no;
	int  live_words;
	int  mismatches;
	logic report_hold;
	logic req_fire;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// program byte, reading zero past the program end
	function automatic logic [mds_pkg::BYTE_W-1:0] program_at(input int c,
		input int unsigned p);
		return (p < PLEN) ? lamp_program[c][p] : '0;
	endfunction

	// advance the predicted channels by one accepted word
	function automatic void apply_request(input request_t w);
		report_t                     rep;
		logic [mds_pkg::BYTE_W-1:0]  op;
		logic [mds_pkg::BYTE_W-1:0]  val;
		logic [mds_pkg::LEVEL_W-1:0] s;
		int unsigned                 p;
		int                          quo;
		if (w.command == mds_pkg::CMD_WRITE) begin
			if (w.channel < NCHAN && w.address < PLEN)
				lamp_program[w.channel][w.address] = w.program_byte;
			return;
		end
		for (int c = 0; c < NCHAN; c++) begin
			if (lamp_wait[c] != 0) begin
				// ramp or delay still counting
				lamp_level[c] = lamp_level[c] + lamp_step[c];
				lamp_wait[c]  = lamp_wait[c] - 1'b1;
			end else if (lamp_pos[c] < PLEN) begin
				p  = lamp_pos[c];
				op = program_at(c, p);
				p++;
				if (op == mds_pkg::OP_END) begin
					p = PLEN;
				end else if (op <= mds_pkg::OP_RAMP_MAX) begin
					// ramp: truncating signed division, positive steps rounded up by one
					val = program_at(c, p);
					p++;
					quo = (int'(val) * 256 - int'(lamp_level[c])) / int'(op);
					s   = quo[mds_pkg::LEVEL_W-1:0];
					if (s != 0 && !s[mds_pkg::LEVEL_W-1])
						s = s + 1'b1;
					lamp_step[c]  = s;
					lamp_level[c] = lamp_level[c] + s;
					lamp_wait[c]  = op - 1'b1;
				end else if (op < mds_pkg::OP_SET) begin
					p = op - mds_pkg::OP_JUMP_BASE;
				end else if (op == mds_pkg::OP_SET) begin
					val = program_at(c, p);
					p++;
					lamp_level[c] = {val, 8'h00};
				end else if (op == mds_pkg::OP_DELAY) begin
					val = program_at(c, p);
					p++;
					lamp_step[c] = '0;
					lamp_wait[c] = val;
				end else begin
					p = PLEN;
				end
				lamp_pos[c] = p[mds_pkg::POS_W-1:0];
			end
			rep.channel_index = c[mds_pkg::CHAN_W-1:0];
			rep.brightness    = lamp_level[c][mds_pkg::LEVEL_W-1:8];
			rep.last          = (c == NCHAN - 1);
			brightness_due.push_back(rep);
		end
	endfunction

	task automatic queue_word(input logic [mds_pkg::CMD_W-1:0] cmd, input int chan,
		input int addr, input int data);
		request_t w;
		w.command      = cmd;
		w.channel      = chan[mds_pkg::CHAN_W-1:0];
		w.address      = addr[mds_pkg::ADDR_W-1:0];
		w.program_byte = data[mds_pkg::BYTE_W-1:0];
		pending_words.push_back(w);
		if (cmd == mds_pkg::CMD_TICK || (chan < NCHAN && addr < PLEN))
			live_words++;
	endtask

	task automatic queue_write(input int chan, input int addr, input int data);
		queue_word(mds_pkg::CMD_WRITE, chan, addr, data);
	endtask

	// tick with random don't-care payload
	task automatic queue_tick();
		queue_word(mds_pkg::CMD_TICK, $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 255));
	endtask

	// a short random program, mostly closed by a jump back so the channel keeps running
	task automatic queue_program(input int chan);
		int at;
		int cmds;
		int pick;
		at   = 0;
		cmds = $urandom_range(1, 4);
		while (cmds > 0 && at < PLEN - 2) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				queue_write(chan, at, ($urandom_range(0, 19) == 0) ?
					$urandom_range(1, mds_pkg::OP_RAMP_MAX) : $urandom_range(1, 6));
				queue_write(chan, at + 1, $urandom_range(0, 255));
				at += 2;
			end else if (pick < 60) begin
				queue_write(chan, at, mds_pkg::OP_SET);
				queue_write(chan, at + 1, $urandom_range(0, 255));
				at += 2;
			end else if (pick < 80) begin
				queue_write(chan, at, mds_pkg::OP_DELAY);
				queue_write(chan, at + 1, ($urandom_range(0, 19) == 0) ?
					$urandom_range(0, 255) : $urandom_range(0, 4));
				at += 2;
			end else if (pick < 90) begin
				queue_write(chan, at, $urandom_range(0, 255));
				at += 1;
			end else begin
				queue_write(chan, at, mds_pkg::OP_JUMP_BASE + $urandom_range(0, PLEN - 1));
				at += 1;
			end
			cmds--;
		end
		pick = $urandom_range(0, 99);
		if (pick < 85)
			queue_write(chan, at, mds_pkg::OP_JUMP_BASE + $urandom_range(0, at));
		else if (pick < 90)
			queue_write(chan, at, mds_pkg::OP_END);
		else if (pick < 95)
			queue_write(chan, at, $urandom_range(mds_pkg::OP_DELAY + 1, 255));
		// otherwise the channel runs into whatever bytes follow
	endtask

	// rewrite a few programs, then tick a while, with stray writes mixed in
	task automatic queue_round();
		repeat ($urandom_range(1, 3))
			queue_program($urandom_range(0, NCHAN - 1));
		if ($urandom_range(0, 3) == 0)
			queue_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 255));
		repeat ($urandom_range(2, 10)) begin
			queue_tick();
			if ($urandom_range(0, 9) == 0)
				queue_write($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 255));
		end
	endtask

	// everything sent has been accepted and answered
	task automatic wait_drained();
		while (pending_words.size() != 0 || req_bus.valid || brightness_due.size() != 0)
			@(posedge clk);
	endtask

	// request driver: hold a word until taken, otherwise offer the next or idle
	always @(negedge clk) begin
		request_t w;
		if (!req_bus.valid || req_fire) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				w = pending_words.pop_front();
				req_bus.command      <= w.command;
				req_bus.channel      <= w.channel;
				req_bus.address      <= w.address;
				req_bus.program_byte <= w.program_byte;
				req_bus.valid        <= 1'b1;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// report side back pressure
	always @(negedge clk) begin
		rsp_bus.ready <= !report_hold && ($urandom_range(0, 99) >= recv_idle);
	end

	// accepted words feed the predictor
	always @(posedge clk) begin
		request_t w;
		req_fire <= req_bus.valid && req_bus.ready;
		if (req_bus.valid && req_bus.ready) begin
			w.command      = req_bus.command;
			w.channel      = req_bus.channel;
			w.address      = req_bus.address;
			w.program_byte = req_bus.program_byte;
			apply_request(w);
		end
	end

	// report monitor
	always @(posedge clk) begin
		report_t exp_rep;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (brightness_due.size() == 0) begin
				$error("unexpected report word: channel_index %0d brightness %0d last %0d",
					rsp_bus.channel_index, rsp_bus.brightness, rsp_bus.last);
				mismatches++;
			end else begin
				exp_rep = brightness_due.pop_front();
				if (rsp_bus.channel_index !== exp_rep.channel_index) begin
					$error("channel_index: expected %0d, got %0d",
						exp_rep.channel_index, rsp_bus.channel_index);
					mismatches++;
				end
				if (rsp_bus.brightness !== exp_rep.brightness) begin
					$error("brightness: expected %0d, got %0d",
						exp_rep.brightness, rsp_bus.brightness);
					mismatches++;
				end
				if (rsp_bus.last !== exp_rep.last) begin
					$error("last: expected %0d, got %0d", exp_rep.last, rsp_bus.last);
					mismatches++;
				end
			end
		end
	end

	// long report stall while ticks keep coming, so the block fills and stalls its input
	initial begin
		wait (phase_no == 2);
		repeat (40) @(posedge clk);
		report_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		report_hold <= 1'b0;
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// reset, stimulus phases and verdict
	initial begin
		foreach (lamp_level[c]) begin
			lamp_level[c] = '0;
			lamp_step[c]  = '0;
			lamp_wait[c]  = '0;
			lamp_pos[c]   = '0;
			foreach (lamp_program[c][a])
				lamp_program[c][a] = '0;
		end
		req_bus.valid        = 1'b0;
		req_bus.command      = mds_pkg::CMD_TICK;
		req_bus.channel      = '0;
		req_bus.address      = '0;
		req_bus.program_byte = '0;
		rsp_bus.ready        = 1'b0;
		report_hold          = 1'b0;
		req_fire             = 1'b0;
		mismatches           = 0;
		live_words           = 0;
		phase_no             = 0;
		send_idle            = 21;
		recv_idle            = 72;
		arst_n               = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full scale ramp in one tick, then a falling ramp with inexact division
		queue_write(0, 0, 1);
		queue_write(0, 1, 255);
		queue_write(0, 2, 7);
		queue_write(0, 3, 0);
		queue_write(0, 4, mds_pkg::OP_JUMP_BASE);
		// set, delay, jump to the final byte, ramp whose target lies past the end
		queue_write(1, 0, mds_pkg::OP_SET);
		queue_write(1, 1, 128);
		queue_write(1, 2, mds_pkg::OP_DELAY);
		queue_write(1, 3, 2);
		queue_write(1, 4, mds_pkg::OP_JUMP_BASE + PLEN - 1);
		queue_write(1, PLEN - 1, 1);
		// ramps that end in a positive step wrapping into the sign bit
		queue_write(2, 0, 1);
		queue_write(2, 1, 64);
		queue_write(2, 2, 1);
		queue_write(2, 3, 128);
		queue_write(2, 4, 1);
		queue_write(2, 5, 0);
		queue_write(2, 6, mds_pkg::OP_JUMP_BASE);
		// longest ramp, and an unknown code on the last channel
		queue_write(20, 0, mds_pkg::OP_RAMP_MAX);
		queue_write(20, 1, 255);
		queue_write(NCHAN - 1, 0, 255);
		// writes outside the store are dropped
		queue_write(31, 31, 8'hAA);
		queue_write(NCHAN, 0, 8'h55);
		queue_write(0, PLEN, 8'hFF);

		// give the remaining channels running programs before the first tick
		for (int c = 3; c < 20; c++)
			queue_program(c);
		repeat (6) queue_tick();
		while (live_words < 190) queue_round();
		wait_drained();

		phase_no  = 1;
		send_idle = 72;
		recv_idle = 21;
		while (live_words < 330) queue_round();
		wait_drained();

		phase_no  = 2;
		send_idle = 0;
		recv_idle = 0;
		repeat (6) queue_tick();
		while (live_words < 470) queue_round();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (brightness_due.size() != 0) begin
			$error("%0d report words never arrived", brightness_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
